[src/texel_light_shader_core_defines.svh]
// ----------------------------------------------------------------------------
// Texel light shader assertion macros
// Shared property forms for the checker of the texel light shader core.
// ----------------------------------------------------------------------------
`ifndef TEXEL_LIGHT_SHADER_CORE_DEFINES_SVH
`define TEXEL_LIGHT_SHADER_CORE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define TLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tls_pkg.sv]
// ----------------------------------------------------------------------------
// Texel light shader package
// Constants, codes, state encoding and unit interface types.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int MAX_LIGHTS  = 8;
  localparam int LIGHT_IDX_W = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int LI_W        = $clog2(MAX_LIGHTS + 1);

  localparam logic [14:0] LEVEL_CAP  = 15'd32640;
  localparam logic [15:0] COLOUR_DIV = 16'd65280;
  localparam logic [14:0] ONE_Q14    = 15'd16384;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SHADE = 1'b1;
  localparam logic KIND_POINT = 1'b1;

  typedef enum logic {
    IT_DIV,
    IT_SQRT
  } iter_mode_t;

  typedef enum logic {
    TGT_NRM,
    TGT_LIGHT
  } norm_tgt_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_K,
    ST_SQRT,
    ST_SWAIT,
    ST_NDIV,
    ST_NWAIT,
    ST_LOAD,
    ST_DOT,
    ST_PDEN,
    ST_PCAP,
    ST_CM1,
    ST_CM2,
    ST_CDIV,
    ST_CWAIT,
    ST_OUT
  } tls_state_t;

  typedef struct packed {
    logic        start;
    iter_mode_t  mode;
    logic [63:0] num;
    logic [55:0] den;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [55:0] q;
  } iter_rsp_t;

  function automatic logic [19:0] mag20(input logic signed [19:0] v);
    mag20 = v[19] ? 20'(-v) : 20'(v);
  endfunction

  function automatic logic [17:0] mag18(input logic signed [17:0] v);
    mag18 = v[17] ? 18'(-v) : 18'(v);
  endfunction

endpackage

[src/texel_light_shader_core.sv]
// ----------------------------------------------------------------------------
// Texel light shader core
// Lambert diffuse light baking for one texel per shade transfer.
// ----------------------------------------------------------------------------
// A load transfer (func 0) writes one light slot; the block is ready again
// in the next cycle and gives no result. A shade transfer (func 1)
// normalizes the normal, then walks light slots 0..light_count-1 (at most
// MAX_LIGHTS) and sends one RGB result. Input is stalled for the whole
// shade. Square roots and the divides by a varying value go through one
// bit-serial unit (32 steps per root, 56 per divide); the divide by 65280
// of a directional light is a shift-add reciprocal multiply. The serial
// unit sets the time: a nonzero normal takes squares, a range search, a
// root and three divides, a zero normal only the squares. Each point light
// adds the same normalize plus three channel divides, each directional
// light the normalize alone on the serial unit, and a light whose vector is
// zero no serial work. The result sits in an output register, so a new
// item is taken while it waits.
// Light slots have no reset; shading a slot never loaded gives any value.
// ----------------------------------------------------------------------------
module texel_light_shader_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [2:0]          in_slot,
  input  logic signed [15:0]  in_vec_x,
  input  logic signed [15:0]  in_vec_y,
  input  logic signed [15:0]  in_vec_z,
  input  logic signed [15:0]  in_nrm_x,
  input  logic signed [15:0]  in_nrm_y,
  input  logic signed [15:0]  in_nrm_z,
  input  logic                in_light_kind,
  input  logic [23:0]         in_light_rgb,
  input  logic [7:0]          in_light_intensity,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue
);
  import tls_pkg::*;

  // light store, no reset
  logic [47:0] vec_mem_r [MAX_LIGHTS];
  logic [32:0] col_mem_r [MAX_LIGHTS];

  logic [3:0]             light_count_r;
  tls_state_t             state_r, state_nxt;
  norm_tgt_t              tgt_r;
  logic [1:0]             idx_r;
  logic [1:0]             ch_r;
  logic [LI_W-1:0]        li_r;
  logic [3:0]             k_r;
  logic signed [19:0]     v_r   [3];
  logic signed [15:0]     pos_r [3];
  logic signed [17:0]     nrm_r [3];
  logic signed [17:0]     lv_r  [3];
  logic [39:0]            l2_r;
  logic [31:0]            len_r;
  logic signed [31:0]     dot_r;
  logic [14:0]            ndl_r;
  logic [55:0]            pden_r;
  logic                   pt_r;
  logic [23:0]            col_r;
  logic [7:0]             inten_r;
  logic [15:0]            acc_r [3];
  logic [59:0]            prod_r;
  logic                   psg_r;
  logic                   out_valid_r;
  logic [7:0]             out_red_r, out_green_r, out_blue_r;

  iter_req_t              ireq;
  iter_rsp_t              irsp;

  logic                   in_acc;
  logic [LI_W-1:0]        cnt;
  logic [LIGHT_IDX_W-1:0] li_idx;
  logic [47:0]            vec_rd;
  logic [32:0]            col_rd;
  logic [39:0]            mul_a;
  logic [19:0]            mul_b;
  logic                   mul_sg;
  logic [39:0]            l2_sum;
  logic signed [31:0]     dot_term;
  logic signed [31:0]     dot_sum;
  logic [14:0]            ndl_val;
  logic signed [17:0]     dot_shr;
  logic                   k_dec;
  logic [61:0]            sq_x;
  logic signed [19:0]     v_sel;
  logic [55:0]            nd_num;
  logic                   cap_case;
  logic                   fast_case;
  logic [22:0]            dir_y;
  logic [46:0]            dir_m;
  logic [14:0]            dir_q;
  logic [14:0]            lvl;
  logic                   acc_en;
  logic [16:0]            acc_sum;
  logic signed [17:0]     q_signed;
  logic [7:0]             ch_col;
  logic                   out_load;
  logic signed [19:0]     raw20 [3];
  logic signed [19:0]     pos20 [3];
  logic signed [19:0]     d8    [3];

  tls_iter_unit u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ireq),
    .rsp   (irsp)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cnt      = (light_count_r > 4'(MAX_LIGHTS)) ? LI_W'(MAX_LIGHTS) : LI_W'(light_count_r);
  assign li_idx   = li_r[LIGHT_IDX_W-1:0];
  assign vec_rd   = vec_mem_r[li_idx];
  assign col_rd   = col_mem_r[li_idx];

  // light vector candidates: raw, position and 8*raw + position
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      raw20[i] = 20'(signed'(vec_rd[16*i +: 16]));
      pos20[i] = 20'(pos_r[i]);
      d8[i]    = (raw20[i] <<< 3) + pos20[i];
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sg = 1'b0;
    v_sel  = '0;
    unique case (idx_r)
      2'd0:    v_sel = v_r[0];
      2'd1:    v_sel = v_r[1];
      2'd2:    v_sel = v_r[2];
      default: v_sel = '0;
    endcase
    unique case (ch_r)
      2'd0:    ch_col = col_r[23:16];
      2'd1:    ch_col = col_r[15:8];
      default: ch_col = col_r[7:0];
    endcase
    priority case (state_r)
      ST_SQ: begin
        mul_a = 40'(mag20(v_sel));
        mul_b = mag20(v_sel);
      end
      ST_DOT: begin
        if (idx_r != 2'd3) begin
          mul_a  = 40'(mag18(nrm_r[idx_r]));
          mul_b  = 20'(mag18(lv_r[idx_r]));
          mul_sg = nrm_r[idx_r][17] ^ lv_r[idx_r][17];
        end
      end
      ST_PDEN: begin
        mul_a = l2_r;
        mul_b = 20'(COLOUR_DIV);
      end
      ST_CM1: begin
        mul_a = 40'(ch_col);
        mul_b = 20'(inten_r);
      end
      ST_CM2: begin
        mul_a = 40'(prod_r[15:0]);
        mul_b = 20'(ndl_r);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // accumulate, shift search and divide operands
  always_comb begin
    l2_sum   = ((idx_r == 2'd1) ? 40'd0 : l2_r) + prod_r[39:0];
    dot_term = psg_r ? -signed'(32'(prod_r[31:0])) : signed'(32'(prod_r[31:0]));
    dot_sum  = ((idx_r == 2'd1) ? 32'sd0 : dot_r) + dot_term;
    dot_shr  = 18'(dot_sum >>> 14);
    if (dot_sum <= 0) begin
      ndl_val = '0;
    end else if (dot_shr > 18'sd16384) begin
      ndl_val = ONE_Q14;
    end else begin
      ndl_val = dot_shr[14:0];
    end
    k_dec    = (k_r != 4'd0) &&
               (({24'd0, l2_r} >> (6'd62 - {1'b0, k_r, 1'b0})) != 64'd0);
    sq_x     = 62'({22'd0, l2_r} << {k_r, 1'b0});
    nd_num   = 56'(56'(mag20(v_sel)) << (5'd14 + 5'(k_r)));
    cap_case = pt_r && (l2_r == 40'd0);
    // directional level: (x >> 8) / 255 as a multiply by ceil(2^31 / 255)
    dir_y    = prod_r[30:8];
    dir_m    = (47'(dir_y) << 23) + (47'(dir_y) << 15) + (47'(dir_y) << 7) + 47'(dir_y);
    dir_q    = 15'(dir_m >> 31);
    fast_case = cap_case || !pt_r;
    lvl      = cap_case ? LEVEL_CAP :
               (!pt_r ? dir_q :
               ((irsp.q > 56'(LEVEL_CAP)) ? LEVEL_CAP : irsp.q[14:0]));
    acc_en   = ((state_r == ST_CDIV) && fast_case) || ((state_r == ST_CWAIT) && irsp.done);
    acc_sum  = 17'(acc_r[ch_r]) + 17'(lvl);
    q_signed = v_sel[19] ? -signed'(18'(irsp.q[16:0])) : signed'(18'(irsp.q[16:0]));
    out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  end

  // requests to the shared root/divide unit
  always_comb begin
    ireq.start = 1'b0;
    ireq.mode  = IT_DIV;
    ireq.num   = '0;
    ireq.den   = '0;
    priority case (state_r)
      ST_SQRT: begin
        ireq.start = 1'b1;
        ireq.mode  = IT_SQRT;
        ireq.num   = {2'b00, sq_x};
      end
      ST_NDIV: begin
        ireq.start = 1'b1;
        ireq.num   = {nd_num, 8'd0};
        ireq.den   = 56'(len_r);
      end
      ST_CDIV: begin
        ireq.start = !fast_case;
        ireq.num   = {prod_r[31:0], 24'd0, 8'd0};
        ireq.den   = pden_r;
      end
      default: begin
        ireq.start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    tls_state_t norm_ret;
    tls_state_t light_ret;
    norm_ret  = (tgt_r == TGT_LIGHT) ? ST_DOT :
                ((cnt == '0) ? ST_OUT : ST_LOAD);
    light_ret = (ch_r != 2'd2) ? ST_CM1 :
                ((li_r + LI_W'(1) == cnt) ? ST_OUT : ST_LOAD);
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && in_func == FUNC_SHADE) state_nxt = ST_SQ;
      ST_SQ:    if (idx_r == 2'd3) state_nxt = (l2_sum == 40'd0) ? norm_ret : ST_K;
      ST_K:     if (!k_dec) state_nxt = ST_SQRT;
      ST_SQRT:  state_nxt = ST_SWAIT;
      ST_SWAIT: if (irsp.done) state_nxt = ST_NDIV;
      ST_NDIV:  state_nxt = ST_NWAIT;
      ST_NWAIT: if (irsp.done) state_nxt = (idx_r == 2'd2) ? norm_ret : ST_NDIV;
      ST_LOAD:  state_nxt = ST_SQ;
      ST_DOT:   if (idx_r == 2'd3) state_nxt = ST_PDEN;
      ST_PDEN:  state_nxt = ST_PCAP;
      ST_PCAP:  state_nxt = ST_CM1;
      ST_CM1:   state_nxt = ST_CM2;
      ST_CM2:   state_nxt = ST_CDIV;
      ST_CDIV:  state_nxt = fast_case ? light_ret : ST_CWAIT;
      ST_CWAIT: if (irsp.done) state_nxt = light_ret;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // configuration and light store writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_count_r <= '0;
    end else if (cfg_wr_en) begin
      light_count_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_func == FUNC_LOAD && 32'(in_slot) < MAX_LIGHTS) begin
      vec_mem_r[LIGHT_IDX_W'(in_slot)] <= {in_vec_z, in_vec_y, in_vec_x};
      col_mem_r[LIGHT_IDX_W'(in_slot)] <= {in_light_kind, in_light_rgb, in_light_intensity};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= 60'(mul_a * mul_b);
    psg_r  <= mul_sg;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_func == FUNC_SHADE) begin
          pos_r[0] <= in_vec_x;
          pos_r[1] <= in_vec_y;
          pos_r[2] <= in_vec_z;
          v_r[0]   <= 20'(in_nrm_x);
          v_r[1]   <= 20'(in_nrm_y);
          v_r[2]   <= 20'(in_nrm_z);
          tgt_r    <= TGT_NRM;
          idx_r    <= '0;
          li_r     <= '0;
          ch_r     <= '0;
          for (int i = 0; i < 3; i++) acc_r[i] <= '0;
        end
      end
      ST_SQ: begin
        if (idx_r != 2'd0) l2_r <= l2_sum;
        idx_r <= idx_r + 2'd1;
        k_r   <= 4'd14;
        if (idx_r == 2'd3 && l2_sum == 40'd0) begin
          // zero vector normalizes to zero
          for (int i = 0; i < 3; i++) begin
            if (tgt_r == TGT_NRM) nrm_r[i] <= '0;
            else lv_r[i] <= '0;
          end
        end
      end
      ST_K: begin
        if (k_dec) k_r <= k_r - 4'd1;
      end
      ST_SWAIT: begin
        if (irsp.done) len_r <= irsp.q[31:0];
      end
      ST_NWAIT: begin
        if (irsp.done) begin
          if (tgt_r == TGT_NRM) nrm_r[idx_r] <= q_signed;
          else lv_r[idx_r] <= q_signed;
          idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
        end
      end
      ST_LOAD: begin
        pt_r    <= col_rd[32];
        col_r   <= col_rd[31:8];
        inten_r <= col_rd[7:0];
        tgt_r   <= TGT_LIGHT;
        idx_r   <= '0;
        ch_r    <= '0;
        if (col_rd[32] == KIND_POINT) begin
          // direction to the light with x and y mirrored
          v_r[0] <= d8[0];
          v_r[1] <= d8[1];
          v_r[2] <= -d8[2];
        end else begin
          for (int i = 0; i < 3; i++) v_r[i] <= -raw20[i];
        end
      end
      ST_DOT: begin
        if (idx_r != 2'd0) dot_r <= dot_sum;
        idx_r <= idx_r + 2'd1;
        if (idx_r == 2'd3) ndl_r <= ndl_val;
      end
      ST_PCAP: begin
        pden_r <= prod_r[55:0];
      end
      default: begin
        pden_r <= pden_r;
      end
    endcase
    if (acc_en) begin
      acc_r[ch_r] <= (acc_sum > 17'(LEVEL_CAP)) ? 16'(LEVEL_CAP) : acc_sum[15:0];
      ch_r        <= (ch_r == 2'd2) ? 2'd0 : ch_r + 2'd1;
      if (ch_r == 2'd2) li_r <= li_r + LI_W'(1);
    end
    if (out_load) begin
      out_red_r   <= acc_r[0][14:7];
      out_green_r <= acc_r[1][14:7];
      out_blue_r  <= acc_r[2][14:7];
    end
  end

  // output register: hold while stalled, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

[src/tls_iter_unit.sv]
// ----------------------------------------------------------------------------
// Texel light shader iterative unit
// Bit-serial restoring divider and square root on one shared subtractor.
// ----------------------------------------------------------------------------
module tls_iter_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  tls_pkg::iter_req_t req,
  output tls_pkg::iter_rsp_t rsp
);
  import tls_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  iter_mode_t  mode_r;
  logic [63:0] num_r;
  logic [55:0] rem_r;
  logic [55:0] q_r;
  logic [55:0] den_r;

  logic [56:0] sh;
  logic [56:0] sub;
  logic [57:0] diff;
  logic        ge;

  always_comb begin
    unique case (mode_r)
      IT_SQRT: begin
        sh  = {rem_r[54:0], num_r[63:62]};
        sub = {q_r[54:0], 2'b01};
      end
      default: begin
        sh  = {rem_r, num_r[63]};
        sub = {1'b0, den_r};
      end
    endcase
    diff = {1'b0, sh} - {1'b0, sub};
    ge   = !diff[57];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == 6'd1);
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= (req.mode == IT_SQRT) ? 6'd32 : 6'd56;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode_r <= req.mode;
      num_r  <= req.num;
      den_r  <= req.den;
      rem_r  <= '0;
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[55:0] : sh[55:0];
      q_r   <= {q_r[54:0], ge};
      num_r <= (mode_r == IT_SQRT) ? {num_r[61:0], 2'b00} : {num_r[62:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

[src/tls_checker.sv]
// ----------------------------------------------------------------------------
// Texel light shader checker
// Port-level properties of the texel light shader core, bound to the top.
// ----------------------------------------------------------------------------
`include "texel_light_shader_core_defines.svh"

module tls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_func,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);
  import tls_pkg::*;

  `TLS_ASSERT_NEXT(a_shade_busy, in_valid && !in_stall && in_func == FUNC_SHADE, in_stall, "shade transfer did not stall the input")
  `TLS_ASSERT_NEXT(a_load_one_cycle, in_valid && !in_stall && in_func == FUNC_LOAD, !in_stall, "load transfer left the input stalled")
  `TLS_ASSERT_NOW(a_result_after_shade, $rose(out_valid), $past(in_stall), "result appeared without a shade in progress")
  `TLS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue), "stalled result changed")

endmodule

bind texel_light_shader_core tls_checker u_tls_checker (.*);

[test/tb_texel_light_shader_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Texel light shader core testbench
// Loads light slots, shades texels under several light counts and checks
// every RGB result against a fixed-point Lambert predictor kept in step
// with each accepted transfer. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_texel_light_shader_core;
  import tls_pkg::*;

  localparam logic KIND_DIR   = 1'b0;
  localparam int   WDOG_LIMIT = 40000;
  localparam int   HOLD_LEN   = 3000;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } texel_rgb_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [3:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic in_func;
  logic [2:0] in_slot;
  logic signed [15:0] in_vec_x, in_vec_y, in_vec_z;
  logic signed [15:0] in_nrm_x, in_nrm_y, in_nrm_z;
  logic in_light_kind;
  logic [23:0] in_light_rgb;
  logic [7:0] in_light_intensity;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_red, out_green, out_blue;

  // Predictor copy of the light store and the count register.
  logic signed [15:0] lamp_vec [MAX_LIGHTS][3];
  logic               lamp_kind [MAX_LIGHTS];
  logic [23:0]        lamp_rgb [MAX_LIGHTS];
  logic [7:0]         lamp_inten [MAX_LIGHTS];
  logic [3:0]         lamp_count;

  texel_rgb_t expected_texels[$];
  int  errors;
  int  idle_cycles;
  bit  no_idle;
  int  stall_left;

  texel_light_shader_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_slot(in_slot),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_nrm_x(in_nrm_x), .in_nrm_y(in_nrm_y), .in_nrm_z(in_nrm_z),
    .in_light_kind(in_light_kind), .in_light_rgb(in_light_rgb),
    .in_light_intensity(in_light_intensity),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned norm_sq(longint v[3]);
    longint unsigned s = 0;
    for (int i = 0; i < 3; i++) s += abs_of(v[i]) * abs_of(v[i]);
    return s;
  endfunction

  // Unit vector in Q2.14; pre-scale by 4^k to keep sqrt precision.
  function automatic void unit_q14(input longint v[3], output longint u[3]);
    longint unsigned l2 = norm_sq(v);
    longint unsigned len;
    longint q;
    int k = 14;
    if (l2 == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (k > 0 && (l2 >> (62 - 2 * k)) != 0) k--;
    len = int_sqrt(l2 << (2 * k));
    for (int i = 0; i < 3; i++) begin
      q = longint'((abs_of(v[i]) << (14 + k)) / len);
      u[i] = (v[i] < 0) ? -q : q;
    end
  endfunction

  function automatic longint unsigned lambert(longint n[3], longint l[3]);
    longint d = n[0] * l[0] + n[1] * l[1] + n[2] * l[2];
    longint unsigned r;
    if (d <= 0) return 0;
    r = longint'(d >>> 14);
    return (r > 16384) ? 16384 : r;
  endfunction

  function automatic texel_rgb_t bake_texel(logic signed [15:0] px, logic signed [15:0] py,
                                            logic signed [15:0] pz, logic signed [15:0] nx,
                                            logic signed [15:0] ny, logic signed [15:0] nz);
    longint pos[3], n_raw[3], n[3], v[3], l[3], d[3];
    longint unsigned acc[3] = '{0, 0, 0};
    longint unsigned ndl, dist2, c, lvl, inten;
    int lights;
    texel_rgb_t res;
    pos = '{longint'(px), longint'(py), longint'(pz)};
    n_raw = '{longint'(nx), longint'(ny), longint'(nz)};
    unit_q14(n_raw, n);
    lights = (lamp_count > MAX_LIGHTS) ? MAX_LIGHTS : lamp_count;
    for (int s = 0; s < lights; s++) begin
      dist2 = 0;
      inten = lamp_inten[s];
      if (lamp_kind[s] != KIND_POINT) begin
        for (int i = 0; i < 3; i++) v[i] = -longint'(lamp_vec[s][i]);
      end else begin
        // Point light: flip x and y of the direction toward the light.
        for (int i = 0; i < 3; i++) d[i] = -8 * longint'(lamp_vec[s][i]) - pos[i];
        dist2 = norm_sq(d);
        v = '{-d[0], -d[1], d[2]};
      end
      unit_q14(v, l);
      ndl = lambert(n, l);
      for (int ch = 0; ch < 3; ch++) begin
        c = (lamp_rgb[s] >> (8 * (2 - ch))) & 8'hFF;
        if (lamp_kind[s] != KIND_POINT) lvl = c * inten * ndl / COLOUR_DIV;
        else if (dist2 == 0) lvl = LEVEL_CAP;
        else lvl = ((c * inten * ndl) << 24) / (COLOUR_DIV * dist2);
        if (lvl > LEVEL_CAP) lvl = LEVEL_CAP;
        acc[ch] += lvl;
        if (acc[ch] > LEVEL_CAP) acc[ch] = LEVEL_CAP;
      end
    end
    res.red   = 8'(acc[0] >> 7);
    res.green = 8'(acc[1] >> 7);
    res.blue  = 8'(acc[2] >> 7);
    return res;
  endfunction

  // ------------------------------------------------------------ driving side

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one transfer and hold it until accepted; valid stays high after.
  task automatic send_item(logic func, logic [2:0] slot,
                           logic signed [15:0] vx, logic signed [15:0] vy,
                           logic signed [15:0] vz, logic signed [15:0] nx,
                           logic signed [15:0] ny, logic signed [15:0] nz,
                           logic kind, logic [23:0] rgb, logic [7:0] inten);
    int gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= func;
    in_slot <= slot;
    in_vec_x <= vx; in_vec_y <= vy; in_vec_z <= vz;
    in_nrm_x <= nx; in_nrm_y <= ny; in_nrm_z <= nz;
    in_light_kind <= kind;
    in_light_rgb <= rgb;
    in_light_intensity <= inten;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if (func == FUNC_LOAD) begin
      lamp_vec[slot] = '{vx, vy, vz};
      lamp_kind[slot] = kind;
      lamp_rgb[slot] = rgb;
      lamp_inten[slot] = inten;
    end else begin
      expected_texels.push_back(bake_texel(vx, vy, vz, nx, ny, nz));
    end
  endtask

  task automatic load_lamp(logic [2:0] slot, logic kind, logic signed [15:0] vx,
                           logic signed [15:0] vy, logic signed [15:0] vz,
                           logic [23:0] rgb, logic [7:0] inten);
    send_item(FUNC_LOAD, slot, vx, vy, vz, 16'($urandom), 16'($urandom),
              16'($urandom), kind, rgb, inten);
  endtask

  task automatic shade(logic signed [15:0] px, logic signed [15:0] py,
                       logic signed [15:0] pz, logic signed [15:0] nx,
                       logic signed [15:0] ny, logic signed [15:0] nz);
    send_item(FUNC_SHADE, 3'($urandom), px, py, pz, nx, ny, nz,
              1'($urandom), 24'($urandom), 8'($urandom));
  endtask

  // Drop valid, wait out every result, then give a trailing load time to land.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_texels.size() == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_light_count(logic [3:0] n);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    lamp_count = n;
  endtask

  function automatic logic signed [15:0] rand_normal_part();
    // Mix full-range values with small ones so both k branches are hit.
    return ($urandom_range(0, 3) == 0) ? 16'($signed($urandom_range(0, 64)) - 32)
                                       : 16'($urandom);
  endfunction

  task automatic shade_random();
    shade(16'($urandom), 16'($urandom), 16'($urandom),
          rand_normal_part(), rand_normal_part(), rand_normal_part());
  endtask

  task automatic load_random(logic [2:0] slot);
    load_lamp(slot, 1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              24'($urandom), 8'($urandom));
  endtask

  // ----------------------------------------------------------------- tests

  task automatic test_no_lights();
    set_light_count(4'd0);
    shade(16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh4000, 16'sh0000, 16'sh0000);
    shade(-16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000);
  endtask

  task automatic test_load_slots();
    // Fill every slot before any shade reads it; cover field extremes.
    load_lamp(3'd0, KIND_DIR, 16'sh0000, 16'sh0000, -16'sh4000, 24'hFFFFFF, 8'hFF);
    load_lamp(3'd1, KIND_POINT, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 24'hFF0000, 8'h80);
    load_lamp(3'd2, KIND_DIR, -16'sh8000, 16'sh7FFF, -16'sh8000, 24'h00FF00, 8'h01);
    load_lamp(3'd3, KIND_POINT, 16'sh0010, 16'sh0020, -16'sh0030, 24'h0000FF, 8'hFF);
    load_lamp(3'd4, KIND_DIR, 16'sh0001, 16'sh0001, 16'sh0001, 24'h000000, 8'h00);
    for (int s = 5; s < MAX_LIGHTS; s++) load_random(3'(s));
  endtask

  task automatic test_directional();
    set_light_count(4'd1);
    shade(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000);
    shade(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, -16'sh4000);
    // Zero normal: nothing lights the texel.
    shade(16'sh1234, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    shade(16'sh0000, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
  endtask

  task automatic test_point_at_texel();
    // Raw (-1,-1,-1) sits at texel (8,8,8): distance zero gives the cap.
    set_light_count(4'd0);
    load_lamp(3'd0, KIND_POINT, -16'sh0001, -16'sh0001, -16'sh0001, 24'h102030, 8'h10);
    set_light_count(4'd1);
    shade(16'sh0008, 16'sh0008, 16'sh0008, 16'sh0000, 16'sh0000, 16'sh4000);
    shade(16'sh0008, 16'sh0008, 16'sh0009, 16'sh0000, 16'sh0000, 16'sh4000);
    load_lamp(3'd0, KIND_DIR, 16'sh0000, 16'sh0000, -16'sh4000, 24'hFFFFFF, 8'hFF);
  endtask

  task automatic test_count_extremes();
    set_light_count(4'd8);
    shade_random();
    shade(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000);
    // Counts above the slot total are clipped.
    set_light_count(4'd15);
    shade_random();
    set_light_count(4'd9);
    shade_random();
  endtask

  task automatic test_backpressure();
    set_light_count(4'd1);
    // Hold the result side long enough for the core to fill and stall input.
    @(negedge clk);
    stall_left = HOLD_LEN;
    repeat (6) shade_random();
    // Pause the sender until everything is back, then resume.
    drain();
    repeat (4) shade_random();
  endtask

  task automatic test_random_mix();
    int n_items;
    for (int ph = 0; ph < 12; ph++) begin
      set_light_count(($urandom_range(0, 99) < 80) ? 4'($urandom_range(0, 2))
                                                   : 4'($urandom_range(3, 15)));
      no_idle = ($urandom_range(0, 3) == 0);
      n_items = 30;
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 2) == 0) load_random(3'($urandom));
        else shade_random();
      end
      no_idle = 1'b0;
    end
  endtask

  // -------------------------------------------------------- result checking

  // Receiver stall: random gaps, or a long hold when stall_left is preset.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  initial begin
    texel_rgb_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_texels.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d",
                   $time, out_red, out_green, out_blue);
          errors++;
        end else begin
          want = expected_texels.pop_front();
          if (out_red !== want.red) begin
            $display("%0t: red expected %0d actual %0d", $time, want.red, out_red);
            errors++;
          end
          if (out_green !== want.green) begin
            $display("%0t: green expected %0d actual %0d", $time, want.green, out_green);
            errors++;
          end
          if (out_blue !== want.blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, want.blue, out_blue);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer on either side.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("tb_texel_light_shader_core: errors");
        $finish;
      end
    end
  end

  initial begin
    errors = 0;
    no_idle = 1'b0;
    lamp_count = 4'd0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd0;
    in_valid = 1'b0;
    in_func = FUNC_LOAD;
    in_slot = 3'd0;
    in_vec_x = '0; in_vec_y = '0; in_vec_z = '0;
    in_nrm_x = '0; in_nrm_y = '0; in_nrm_z = '0;
    in_light_kind = KIND_DIR;
    in_light_rgb = '0;
    in_light_intensity = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_no_lights();
    test_load_slots();
    test_directional();
    test_point_at_texel();
    test_count_extremes();
    test_backpressure();
    test_random_mix();

    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_texel_light_shader_core: clean");
    end else begin
      $display("tb_texel_light_shader_core: errors");
    end
    $finish;
  end

endmodule
